// ===== rtl/chacha20_key_erasure_rng_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CHACHA20_KEY_ERASURE_RNG_MACROS_SVH
`define CHACHA20_KEY_ERASURE_RNG_MACROS_SVH

// An implication that must hold at every clock edge outside reset.
`define CKR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define CKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ckr_pkg.sv =====
`timescale 1ns / 1ps
package ckr_pkg;

  localparam int MAX_REQUEST_BYTES_DEF = 512;
  localparam int RESULT_LIMIT = 64;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_FILL = 1'b1;

  localparam logic [2:0] CFG_SEED0 = 3'd0;
  localparam logic [2:0] CFG_SEED1 = 3'd1;
  localparam logic [2:0] CFG_SEED2 = 3'd2;
  localparam logic [2:0] CFG_SEED3 = 3'd3;
  localparam logic [2:0] CFG_PRESENT = 3'd4;

  localparam logic [31:0] NONCE_MASK0 = 32'ha5a5a5a5;
  localparam logic [31:0] NONCE_MASK1 = 32'h3c6ef372;
  localparam logic [31:0] NONCE_MASK2 = 32'h9e3779b9;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef struct packed {
    logic       operation;
    logic [9:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] random_data;
    logic [3:0]  valid_bytes;
    logic        last;
  } out_item_t;

  // Word indexes a, b, c, d of quarter round q (0..7) of a double round.
  function automatic logic [15:0] qr_index(input logic [2:0] q);
    logic [15:0] r;
    unique case (q)
      3'd0: r = {4'd0, 4'd4, 4'd8, 4'd12};
      3'd1: r = {4'd1, 4'd5, 4'd9, 4'd13};
      3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
      3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
      3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
      3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
      3'd6: r = {4'd2, 4'd7, 4'd8, 4'd13};
      default: r = {4'd3, 4'd4, 4'd9, 4'd14};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/chacha20_key_erasure_rng.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                                 | Handshake
// request   | in_start, in_busy, in_item            | taken when start and not busy
// result    | out_strobe, out_item                  | one cycle per strobe, no stall
// config    | cfg_we, cfg_index, cfg_data           | written when cfg_we is high
//
// An initialize request, a zero-length fill or a fill while unseeded drives its single
// result through the S_ONE state and the output register. A fill block runs a load,
// 160 half quarter-round steps, 16 feed-forward adds and up to 8 results, and a
// request of up to 512 bytes runs as many blocks as it needs.
// The receiver cannot stall; busy drops as the last result appears. Reset is
// synchronous, active low, and clears key, nonce, counter, seeds and sequencer.
module chacha20_key_erasure_rng
  import ckr_pkg::*;
#(
  parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        in_busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // The request limit is the smaller of the parameter and what 64 results hold.
  localparam int LIMIT = (MAX_REQUEST_BYTES > RESULT_LIMIT * 8) ? RESULT_LIMIT * 8
                                                               : MAX_REQUEST_BYTES;
  localparam logic [9:0] LIMIT_V = 10'(LIMIT);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ONE   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] seed_r [4];
  logic        present_r;
  logic [31:0] key_r [8];
  logic [31:0] nonce_r [3];
  logic [31:0] ctr_r;
  logic        seeded_r;
  logic [31:0] w_r [16];
  logic [7:0]  step_r;
  logic [9:0]  left_r;
  logic        one_status_r;
  logic        strobe_r;
  out_item_t   item_r;

  // Shared half quarter-round unit: even steps rotate by 16 and 12, odd steps
  // by 8 and 7, so each cycle holds only two dependent adds.
  logic [15:0] qi;
  logic [3:0]  ia, ib, ic, id;
  logic        half;
  logic [31:0] a0, b0, c0, d0, bx, dx;
  logic [9:0]  want;

  assign half = step_r[0];
  assign qi = qr_index(step_r[3:1]);
  assign ia = qi[15:12];
  assign ib = qi[11:8];
  assign ic = qi[7:4];
  assign id = qi[3:0];

  always_comb begin
    a0 = w_r[ia] + w_r[ib];
    dx = w_r[id] ^ a0;
    d0 = half ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c0 = w_r[ic] + d0;
    bx = w_r[ib] ^ c0;
    b0 = half ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
  end

  assign want = (in_item.request_bytes > LIMIT_V) ? LIMIT_V : in_item.request_bytes;
  assign in_busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_start) begin
        if (in_item.operation == OP_FILL && want != '0 && seeded_r) state_nxt = S_LOAD;
        else state_nxt = S_ONE;
      end
      S_ONE:   state_nxt = S_IDLE;
      S_LOAD:  state_nxt = S_ROUND;
      S_ROUND: if (step_r == 8'd159) state_nxt = S_ADD;
      S_ADD:   if (step_r[3:0] == 4'd15) state_nxt = S_EMIT;
      S_EMIT: begin
        if (left_r <= 10'd8) state_nxt = S_IDLE;
        else if (step_r[2:0] == 3'd7) state_nxt = S_LOAD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [63:0] word;
  logic [3:0]  nb;
  logic [63:0] mask;
  assign word = {w_r[{step_r[2:0], 1'b1}], w_r[{step_r[2:0], 1'b0}]};
  assign nb = (left_r >= 10'd8) ? 4'd8 : left_r[3:0];
  assign mask = (nb == 4'd8) ? '1 : ((64'd1 << {nb[2:0], 3'b000}) - 64'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      present_r <= 1'b0;
      seeded_r  <= 1'b0;
      ctr_r     <= '0;
      strobe_r  <= 1'b0;
      step_r    <= '0;
      for (int i = 0; i < 4; i++) seed_r[i] <= '0;
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEED0:   seed_r[0] <= cfg_data;
          CFG_SEED1:   seed_r[1] <= cfg_data;
          CFG_SEED2:   seed_r[2] <= cfg_data;
          CFG_SEED3:   seed_r[3] <= cfg_data;
          CFG_PRESENT: present_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_start) begin
          left_r <= want;
          step_r <= '0;
          if (in_item.operation == OP_INIT) begin
            one_status_r <= ~present_r;
            seeded_r <= present_r;
            if (present_r) begin
              for (int i = 0; i < 8; i++)
                key_r[i] <= seed_r[i >> 1][(i & 1) * 32 +: 32];
              nonce_r[0] <= seed_r[0][31:0] ^ NONCE_MASK0;
              nonce_r[1] <= seed_r[1][63:32] ^ NONCE_MASK1;
              nonce_r[2] <= seed_r[2][63:32] ^ NONCE_MASK2;
              ctr_r <= 32'd1;
            end
          end else begin
            one_status_r <= (want != '0) && !seeded_r;
          end
        end
        S_ONE: begin
          strobe_r <= 1'b1;
          item_r   <= '{status: one_status_r, random_data: '0, valid_bytes: '0,
                        last: 1'b1};
        end
        S_LOAD: begin
          w_r[0] <= SIGMA0; w_r[1] <= SIGMA1; w_r[2] <= SIGMA2; w_r[3] <= SIGMA3;
          for (int i = 0; i < 8; i++) w_r[4 + i] <= key_r[i];
          w_r[12] <= ctr_r;
          for (int i = 0; i < 3; i++) w_r[13 + i] <= nonce_r[i];
          step_r <= '0;
        end
        S_ROUND: begin
          w_r[ia] <= a0; w_r[ib] <= b0; w_r[ic] <= c0; w_r[id] <= d0;
          step_r <= (step_r == 8'd159) ? 8'd0 : step_r + 8'd1;
        end
        S_ADD: begin
          // Feed-forward add, one word per cycle; init words rebuilt from state.
          priority if (step_r[3:0] < 4'd4) begin
            w_r[step_r[3:0]] <= w_r[step_r[3:0]] +
              ((step_r[1:0] == 2'd0) ? SIGMA0 : (step_r[1:0] == 2'd1) ? SIGMA1 :
               (step_r[1:0] == 2'd2) ? SIGMA2 : SIGMA3);
          end else if (step_r[3:0] < 4'd12) begin
            w_r[step_r[3:0]] <= w_r[step_r[3:0]] + key_r[3'(step_r[3:0] - 4'd4)];
          end else if (step_r[3:0] == 4'd12) begin
            w_r[12] <= w_r[12] + ctr_r;
          end else begin
            w_r[step_r[3:0]] <= w_r[step_r[3:0]] + nonce_r[2'(step_r[3:0] - 4'd13)];
          end
          if (step_r[3:0] == 4'd15) begin
            step_r <= '0;
            // Rekey from the finished key words and advance the counter.
            for (int i = 0; i < 8; i++) key_r[i] <= w_r[i];
            ctr_r <= ctr_r + 32'd1;
            if (ctr_r == '1) begin
              nonce_r[0] <= nonce_r[0] + 32'd1;
              if (nonce_r[0] == '1) begin
                nonce_r[1] <= nonce_r[1] + 32'd1;
                if (nonce_r[1] == '1) nonce_r[2] <= nonce_r[2] + 32'd1;
              end
            end
          end else begin
            step_r <= step_r + 8'd1;
          end
        end
        S_EMIT: begin
          strobe_r <= 1'b1;
          item_r   <= '{status: 1'b0, random_data: word & mask, valid_bytes: nb,
                        last: (left_r <= 10'd8)};
          left_r   <= left_r - 10'(nb);
          step_r   <= step_r + 8'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ===== rtl/ckr_checker.sv =====
`timescale 1ns / 1ps
`include "chacha20_key_erasure_rng_macros.svh"
module ckr_checker
  import ckr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_start,
  input logic      in_busy,
  input out_item_t out_item,
  input logic      out_strobe
);

  // Results only come while a request is in progress.
  `CKR_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, $past(in_busy), "result without request")
  // A taken request makes the block busy.
  `CKR_ASSERT_NEXT(a_take_busy, clk, rst_n, in_start && !in_busy, in_busy, "not busy after request")
  // The block is already idle while its last result is on the ports.
  `CKR_ASSERT_IMP(a_last_idle, clk, rst_n, out_strobe && out_item.last, !in_busy, "busy after last")
  // At most eight bytes per result; partial words only on the last one.
  `CKR_ASSERT_IMP(a_bytes, clk, rst_n, out_strobe && !out_item.last, out_item.valid_bytes == 4'd8, "short word")

endmodule

bind chacha20_key_erasure_rng ckr_checker u_ckr_checker (
  .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
  .out_item(out_item), .out_strobe(out_strobe)
);

// ===== verif/chacha20_key_erasure_rng_tb.sv =====
`timescale 1ns / 1ps
module chacha20_key_erasure_rng_tb;
  import ckr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_start;
  logic        in_busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  chacha20_key_erasure_rng dut (
    .clk(clk), .rst_n(rst_n),
    .in_start(in_start), .in_busy(in_busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the generator state and of the seed registers.
  logic [63:0] seed_shadow [4];
  logic        present_shadow;
  logic [31:0] key_shadow [8];
  logic [31:0] nonce_shadow [3];
  logic [31:0] ctr_shadow;
  logic        seeded_shadow;

  // Results that the accepted requests still owe, oldest first.
  out_item_t pending_words [$];
  int        error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Even with every request at the longest length, all requests and their gaps
  // stay well below this bound.
  initial begin
    #20ms;
    $display("chacha20_key_erasure_rng_tb failed");
    $finish;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Computes one ChaCha20 block from the shadow key, counter and nonce.
  task automatic chacha_block(output logic [31:0] blk [16]);
    logic [31:0] st [16];
    logic [31:0] w [16];
    int a, b, c, d;
    st[0] = SIGMA0; st[1] = SIGMA1; st[2] = SIGMA2; st[3] = SIGMA3;
    for (int i = 0; i < 8; i++) st[4 + i] = key_shadow[i];
    st[12] = ctr_shadow;
    for (int i = 0; i < 3; i++) st[13 + i] = nonce_shadow[i];
    w = st;
    for (int r = 0; r < 10; r++) begin
      for (int q = 0; q < 8; q++) begin
        // Column rounds first, then the diagonals.
        a = q % 4;
        if (q < 4) begin
          b = a + 4; c = a + 8; d = a + 12;
        end else begin
          b = 4 + (a + 1) % 4; c = 8 + (a + 2) % 4; d = 12 + (a + 3) % 4;
        end
        w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) blk[i] = w[i] + st[i];
  endtask

  function automatic out_item_t word_of(input logic st, input logic [63:0] data,
                                        input int n, input logic fin);
    out_item_t r;
    r.status = st;
    r.random_data = data;
    r.valid_bytes = 4'(n);
    r.last = fin;
    return r;
  endfunction

  // Advances the shadow state for one request and queues its results.
  task automatic predict_request(input in_item_t req);
    logic [31:0] blk [16];
    logic [63:0] word;
    int want, done, n;
    if (req.operation == OP_INIT) begin
      if (!present_shadow) begin
        // Without a seed only the seeded flag drops; key and nonce stay.
        seeded_shadow = 1'b0;
        pending_words.push_back(word_of(1'b1, '0, 0, 1'b1));
        return;
      end
      for (int i = 0; i < 8; i++) key_shadow[i] = seed_shadow[i / 2][32 * (i % 2) +: 32];
      nonce_shadow[0] = seed_shadow[0][31:0] ^ NONCE_MASK0;
      nonce_shadow[1] = seed_shadow[1][63:32] ^ NONCE_MASK1;
      nonce_shadow[2] = seed_shadow[2][63:32] ^ NONCE_MASK2;
      ctr_shadow = 32'd1;
      seeded_shadow = 1'b1;
      pending_words.push_back(word_of(1'b0, '0, 0, 1'b1));
      return;
    end
    want = req.request_bytes;
    if (want > MAX_REQUEST_BYTES_DEF) want = MAX_REQUEST_BYTES_DEF;
    if (want == 0) begin
      pending_words.push_back(word_of(1'b0, '0, 0, 1'b1));
      return;
    end
    if (!seeded_shadow) begin
      pending_words.push_back(word_of(1'b1, '0, 0, 1'b1));
      return;
    end
    done = 0;
    while (done < want) begin
      chacha_block(blk);
      for (int i = 0; i < 8 && done < want; i++) begin
        word = {blk[2 * i + 1], blk[2 * i]};
        n = (want - done > 8) ? 8 : want - done;
        // The unused top bytes of a partial word read as zero.
        if (n < 8) word &= (64'd1 << (n * 8)) - 64'd1;
        done += n;
        pending_words.push_back(word_of(1'b0, word, n, done >= want));
      end
      // Fast key erasure: the first 32 bytes become the next key, even when
      // the block was only partly used.
      for (int i = 0; i < 8; i++) key_shadow[i] = blk[i];
      ctr_shadow++;
      if (ctr_shadow == 0) begin
        nonce_shadow[0]++;
        if (nonce_shadow[0] == 0) begin
          nonce_shadow[1]++;
          if (nonce_shadow[1] == 0) nonce_shadow[2]++;
        end
      end
    end
  endtask

  // Compares every strobed result with the oldest expected one.
  always @(posedge clk) begin
    out_item_t exp_word;
    if (rst_n && out_strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result: data %h", out_item.random_data);
        error_count++;
      end else begin
        exp_word = pending_words.pop_front();
        if (out_item.status !== exp_word.status) begin
          $error("status: expected %0d, got %0d", exp_word.status, out_item.status);
          error_count++;
        end
        if (out_item.random_data !== exp_word.random_data) begin
          $error("random_data: expected %h, got %h", exp_word.random_data,
                 out_item.random_data);
          error_count++;
        end
        if (out_item.valid_bytes !== exp_word.valid_bytes) begin
          $error("valid_bytes: expected %0d, got %0d", exp_word.valid_bytes,
                 out_item.valid_bytes);
          error_count++;
        end
        if (out_item.last !== exp_word.last) begin
          $error("last: expected %0d, got %0d", exp_word.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  // Sends one request and predicts its results once it is taken.
  task automatic send_request(input logic op, input logic [9:0] nbytes);
    in_item_t req;
    req.operation = op;
    req.request_bytes = nbytes;
    @(negedge clk);
    in_start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_busy);
    predict_request(req);
    @(negedge clk);
    in_start <= 1'b0;
    // The burst pattern: mostly back to back, sometimes a random gap.
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(negedge clk);
  endtask

  // Waits until all results have arrived and the block has gone idle.
  task automatic drain;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRESENT) present_shadow = val[0];
    else seed_shadow[idx] = val;
  endtask

  task automatic load_seed(input logic [63:0] s0, s1, s2, s3, input logic pres);
    drain();
    write_reg(CFG_SEED0, s0);
    write_reg(CFG_SEED1, s1);
    write_reg(CFG_SEED2, s2);
    write_reg(CFG_SEED3, s3);
    write_reg(CFG_PRESENT, {63'd0, pres});
  endtask

  // Unseeded fills, initialize without a seed, zero and oversized lengths.
  task automatic test_unseeded;
    send_request(OP_FILL, 10'd16);
    send_request(OP_INIT, 10'd0);
    send_request(OP_FILL, 10'd0);
    send_request(OP_FILL, 10'd1023);
  endtask

  // Seeded fills with extreme seeds, partial words and partial blocks.
  task automatic test_directed_fill;
    load_seed('0, '0, '0, '0, 1'b1);
    send_request(OP_INIT, 10'h3ff);
    send_request(OP_FILL, 10'd1);
    send_request(OP_FILL, 10'd7);
    send_request(OP_FILL, 10'd8);
    send_request(OP_FILL, 10'd65);
    send_request(OP_FILL, 10'd0);
    send_request(OP_FILL, 10'd512);
    send_request(OP_FILL, 10'd513);
    send_request(OP_FILL, 10'd1023);
    load_seed('1, '1, '1, '1, 1'b1);
    send_request(OP_INIT, 10'd5);
    send_request(OP_FILL, 10'd64);
    send_request(OP_FILL, 10'd3);
    // Dropping the seed clears only the seeded flag.
    load_seed('1, '1, '1, '1, 1'b0);
    send_request(OP_INIT, 10'd0);
    send_request(OP_FILL, 10'd9);
  endtask

  // Nonce words that are all ones, the state from which a counter wrap
  // would carry through every nonce word.
  task automatic test_counter_wrap;
    // Seed bytes that make every nonce word all ones after masking.
    load_seed({32'h0, ~NONCE_MASK0}, {~NONCE_MASK1, 32'h0},
              {~NONCE_MASK2, 32'h0}, 64'h0123456789abcdef, 1'b1);
    send_request(OP_INIT, 10'd0);
    // The counter restarts at 1 and only moves one step per block, so the
    // wrap itself is out of reach from the ports; this checks the blocks
    // built on the all-ones nonce.
    send_request(OP_FILL, 10'd128);
  endtask

  // Random seeds and requests, mostly small fills on a seeded generator.
  task automatic test_random;
    int r;
    for (int phase = 0; phase < 5; phase++) begin
      load_seed({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, (phase != 3) || $urandom_range(0, 1));
      send_request(OP_INIT, 10'($urandom));
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_request(OP_INIT, 10'($urandom));
        else if (r < 10) send_request(OP_FILL, 10'($urandom));
        else if (r < 14) send_request(OP_FILL, 10'd0);
        else send_request(OP_FILL, 10'($urandom_range(1, 80)));
        // Hold off once per phase until the generator has drained.
        if (k == 15) drain();
      end
    end
  endtask

  initial begin
    error_count = 0;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SEED0;
    cfg_data = '0;
    for (int i = 0; i < 4; i++) seed_shadow[i] = '0;
    for (int i = 0; i < 8; i++) key_shadow[i] = '0;
    for (int i = 0; i < 3; i++) nonce_shadow[i] = '0;
    present_shadow = 1'b0;
    ctr_shadow = '0;
    seeded_shadow = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unseeded();
    test_directed_fill();
    test_counter_wrap();
    test_random();
    drain();
    repeat (20) @(posedge clk);

    if (error_count == 0 && pending_words.size() == 0) begin
      $display("chacha20_key_erasure_rng_tb passed");
    end else begin
      $display("chacha20_key_erasure_rng_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ckr_pkg.sv
rtl/chacha20_key_erasure_rng.sv
rtl/ckr_checker.sv
verif/chacha20_key_erasure_rng_tb.sv
